// ===== rtl/sorted_timeout_timer_pool_defines.svh =====
// assertion helpers for the timer pool checker
`ifndef SORTED_TIMEOUT_TIMER_POOL_DEFINES_SVH
`define SORTED_TIMEOUT_TIMER_POOL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define STP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define STP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/stp_pkg.sv =====
package stp_pkg;

	// operation codes
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_ALLOC  = 3'd1;
	localparam logic [2:0] OP_FREE   = 3'd2;
	localparam logic [2:0] OP_BIND   = 3'd3;
	localparam logic [2:0] OP_ARM    = 3'd4;
	localparam logic [2:0] OP_CANCEL = 3'd5;
	localparam logic [2:0] OP_CALL   = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_EXPIRY = 2'd2;
	localparam logic [1:0] KIND_TASK   = 2'd3;

	// slot status codes
	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	// configuration register indexes
	localparam logic REG_TASK_SLOT   = 1'b0;
	localparam logic REG_TASK_ENABLE = 1'b1;

	typedef struct packed {
		logic [2:0]         op;
		logic [4:0]         slot;
		logic [31:0]        delay;
		logic [7:0]         queue_id;
		logic signed [31:0] payload;
		logic               auto_cancel;
	} stp_in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [4:0]         slot_out;
		logic               ok;
		logic [7:0]         queue_out;
		logic signed [31:0] payload_out;
		logic               last;
	} stp_out_t;

	// row-wide command to the sorted cells
	typedef struct packed {
		logic ins;
		logic rem;
		logic pop;
	} stp_cell_ctl_t;

endpackage

// ===== rtl/stp_ram.sv =====
module stp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/stp_cell.sv =====
module stp_cell #(
	parameter int IDW = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stp_pkg::stp_cell_ctl_t ctl,
	input  logic [IDW-1:0]        new_id,
	input  logic [31:0]           new_exp,
	input  logic [IDW-1:0]        rem_id,
	// left neighbor (closer to head)
	input  logic                  l_v,
	input  logic [IDW-1:0]        l_id,
	input  logic [31:0]           l_exp,
	input  logic                  l_ge,
	input  logic                  l_after,
	// right neighbor
	input  logic                  r_v,
	input  logic [IDW-1:0]        r_id,
	input  logic [31:0]           r_exp,
	output logic                  v,
	output logic [IDW-1:0]        id,
	output logic [31:0]           exp_t,
	output logic                  ge,
	output logic                  after
);

	logic           v_q;
	logic [IDW-1:0] id_q;
	logic [31:0]    exp_q;
	logic           match;

	// new entry belongs at or before this cell; empty cells always qualify
	assign ge    = !v_q || (new_exp <= exp_q);
	assign match = ctl.rem && v_q && (id_q == rem_id);
	assign after = l_after || match;

	assign v     = v_q;
	assign id    = id_q;
	assign exp_t = exp_q;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctl.pop || (ctl.rem && after)) begin
			v_q <= r_v;
		end else if (ctl.ins && ge) begin
			v_q <= l_ge ? l_v : 1'b1;
		end
	end

	// entry contents, shift left on removal, right on insertion
	always_ff @(posedge clk) begin
		if (ctl.pop || (ctl.rem && after)) begin
			id_q  <= r_id;
			exp_q <= r_exp;
		end else if (ctl.ins && ge) begin
			id_q  <= l_ge ? l_id : new_id;
			exp_q <= l_ge ? l_exp : new_exp;
		end
	end

endmodule

// ===== rtl/sorted_timeout_timer_pool.sv =====
// Free, bind and unused ops finish at accept; arm inserts its timer in a second
// state; alloc and cancel answer in the cycle after accept. Cancel all: one slot a cycle.
// Tick pops each expired head and emits an expiry event for all but the task slot,
// with queue id and payload from the single memory read port, then any task switch.
// Results are registered and shown for one cycle; the receiver cannot stall.
// Reset clears status, the sorted cell row, tick count and configuration registers at once.
module sorted_timeout_timer_pool #(
	parameter int NUM_TIMERS    = 32,
	parameter int QUEUE_ID_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  stp_pkg::stp_in_t item,
	output logic             result_valid,
	output stp_pkg::stp_out_t result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [4:0]       cfg_wdata
);

	localparam int SW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int RW = QUEUE_ID_BITS + 32;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ARM2 = 3'd1;
	localparam logic [2:0] S_TCHK = 3'd2;
	localparam logic [2:0] S_TEMIT = 3'd3;
	localparam logic [2:0] S_CALL = 3'd4;

	logic [2:0]               state_q;
	logic [31:0]              tick_q;
	logic [4:0]               task_slot_q;
	logic                     task_en_q;
	logic [1:0]               status_q [NUM_TIMERS];
	logic                     ac_q [NUM_TIMERS];
	logic                     ts_q;
	logic [SW-1:0]            emit_id_q;
	logic [SW-1:0]            arm_id_q;
	logic [31:0]              arm_exp_q;
	logic [CW-1:0]            cnt_q;
	logic                     chk_v_q;
	logic [SW-1:0]            chk_idx_q;
	logic [QUEUE_ID_BITS-1:0] cq_q;
	logic                     res_v_q;
	stp_pkg::stp_out_t        res_q;

	logic                     acc;
	logic [SW-1:0]            s_idx;
	logic                     s_ok;
	logic [1:0]               cur_st;
	logic                     found_ok;
	logic [SW-1:0]            found_idx;
	logic                     head_exp;
	logic                     is_task;
	logic                     call_hit;
	stp_pkg::stp_cell_ctl_t   ctl;
	logic [SW-1:0]            rem_id;
	logic [SW-1:0]            ram_raddr;
	logic [RW-1:0]            ram_rdata;
	logic                     ram_we;

	logic                     v_w   [NUM_TIMERS];
	logic [SW-1:0]            id_w  [NUM_TIMERS];
	logic [31:0]              exp_w [NUM_TIMERS];
	logic                     ge_w  [NUM_TIMERS];
	logic                     aft_w [NUM_TIMERS];

	assign acc    = start && !busy;
	assign s_idx  = SW'(item.slot);
	assign s_ok   = 32'(item.slot) < 32'(NUM_TIMERS);
	assign cur_st = status_q[s_idx];
	assign busy   = (state_q != S_IDLE) || res_v_q;

	assign result_valid = res_v_q;
	assign result       = res_q;

	// head of the sorted row and whether it has expired
	assign head_exp = v_w[0] && (exp_w[0] <= tick_q);
	assign is_task  = task_en_q && (32'(id_w[0]) == 32'(task_slot_q));

	// cancel-all match on the slot read last cycle
	assign call_hit = chk_v_q && (status_q[chk_idx_q] != stp_pkg::ST_FREE) &&
		ac_q[chk_idx_q] && (ram_rdata[RW-1:32] == cq_q);

	// lowest free slot
	always_comb begin
		found_ok  = 1'b0;
		found_idx = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (status_q[i] == stp_pkg::ST_FREE) begin
				found_ok  = 1'b1;
				found_idx = SW'(i);
			end
		end
	end

	// cell row command and memory read address
	always_comb begin
		ctl       = '0;
		rem_id    = s_idx;
		ram_raddr = id_w[0];
		ram_we    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (item.op)
						stp_pkg::OP_FREE:   ctl.rem = s_ok;
						stp_pkg::OP_ARM:    ctl.rem = s_ok && (cur_st != stp_pkg::ST_FREE);
						stp_pkg::OP_CANCEL: ctl.rem = s_ok && (cur_st == stp_pkg::ST_RUN);
						stp_pkg::OP_BIND:   ram_we  = s_ok;
						default: ;
					endcase
				end
			end
			S_ARM2: ctl.ins = 1'b1;
			S_TCHK: ctl.pop = head_exp;
			S_CALL: begin
				rem_id    = chk_idx_q;
				ctl.rem   = call_hit;
				ram_raddr = cnt_q[SW-1:0];
			end
			default: ;
		endcase
	end

	// queue id and payload per slot
	stp_ram #(.WIDTH(RW), .DEPTH(NUM_TIMERS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (s_idx),
		.wdata ({QUEUE_ID_BITS'(item.queue_id), item.payload}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sorted row of running timers, head at cell 0
	for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
		logic           l_v, l_ge, l_after, r_v;
		logic [SW-1:0]  l_id, r_id;
		logic [31:0]    l_exp, r_exp;
		if (g == 0) begin : g_first
			assign l_v     = 1'b0;
			assign l_id    = '0;
			assign l_exp   = '0;
			assign l_ge    = 1'b0;
			assign l_after = 1'b0;
		end else begin : g_mid
			assign l_v     = v_w[g-1];
			assign l_id    = id_w[g-1];
			assign l_exp   = exp_w[g-1];
			assign l_ge    = ge_w[g-1];
			assign l_after = aft_w[g-1];
		end
		if (g == NUM_TIMERS - 1) begin : g_last
			assign r_v   = 1'b0;
			assign r_id  = '0;
			assign r_exp = '0;
		end else begin : g_inner
			assign r_v   = v_w[g+1];
			assign r_id  = id_w[g+1];
			assign r_exp = exp_w[g+1];
		end
		stp_cell #(.IDW(SW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.new_id  (arm_id_q),
			.new_exp (arm_exp_q),
			.rem_id  (rem_id),
			.l_v     (l_v),
			.l_id    (l_id),
			.l_exp   (l_exp),
			.l_ge    (l_ge),
			.l_after (l_after),
			.r_v     (r_v),
			.r_id    (r_id),
			.r_exp   (r_exp),
			.v       (v_w[g]),
			.id      (id_w[g]),
			.exp_t   (exp_w[g]),
			.ge      (ge_w[g]),
			.after   (aft_w[g])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_slot_q <= '0;
			task_en_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				stp_pkg::REG_TASK_SLOT:   task_slot_q <= cfg_wdata;
				stp_pkg::REG_TASK_ENABLE: task_en_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// sequencer, slot status and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tick_q  <= '0;
			ts_q    <= 1'b0;
			cnt_q   <= '0;
			chk_v_q <= 1'b0;
			res_v_q <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				status_q[i] <= stp_pkg::ST_FREE;
				ac_q[i]     <= 1'b0;
			end
		end else begin
			res_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (item.op)
							stp_pkg::OP_TICK: begin
								tick_q  <= tick_q + 32'd1;
								ts_q    <= 1'b0;
								state_q <= S_TCHK;
							end
							stp_pkg::OP_ALLOC: begin
								if (found_ok) begin
									status_q[found_idx] <= stp_pkg::ST_ALLOC;
									ac_q[found_idx]     <= 1'b0;
								end
								res_v_q <= 1'b1;
								res_q   <= '{kind: stp_pkg::KIND_ALLOC,
									slot_out: 5'(found_idx), ok: found_ok,
									queue_out: '0, payload_out: '0, last: 1'b1};
							end
							stp_pkg::OP_FREE: begin
								if (s_ok) begin
									status_q[s_idx] <= stp_pkg::ST_FREE;
								end
							end
							stp_pkg::OP_BIND: begin
								if (s_ok) begin
									ac_q[s_idx] <= item.auto_cancel;
								end
							end
							stp_pkg::OP_ARM: begin
								if (s_ok && (cur_st != stp_pkg::ST_FREE)) begin
									status_q[s_idx] <= stp_pkg::ST_RUN;
									arm_id_q        <= s_idx;
									arm_exp_q       <= item.delay + tick_q;
									state_q         <= S_ARM2;
								end
							end
							stp_pkg::OP_CANCEL: begin
								if (s_ok && (cur_st == stp_pkg::ST_RUN)) begin
									status_q[s_idx] <= stp_pkg::ST_ALLOC;
								end
								res_v_q <= 1'b1;
								res_q   <= '{kind: stp_pkg::KIND_CANCEL,
									slot_out: item.slot,
									ok: s_ok && (cur_st == stp_pkg::ST_RUN),
									queue_out: '0, payload_out: '0, last: 1'b1};
							end
							stp_pkg::OP_CALL: begin
								cq_q    <= QUEUE_ID_BITS'(item.queue_id);
								cnt_q   <= '0;
								chk_v_q <= 1'b0;
								state_q <= S_CALL;
							end
							default: ;
						endcase
					end
				end
				S_ARM2: state_q <= S_IDLE;
				S_TCHK: begin
					if (head_exp) begin
						status_q[id_w[0]] <= stp_pkg::ST_ALLOC;
						if (is_task) begin
							ts_q <= 1'b1;
						end else begin
							emit_id_q <= id_w[0];
							state_q   <= S_TEMIT;
						end
					end else begin
						// task switch closes the tick
						if (ts_q) begin
							res_v_q <= 1'b1;
							res_q   <= '{kind: stp_pkg::KIND_TASK, slot_out: task_slot_q,
								ok: 1'b0, queue_out: '0, payload_out: '0, last: 1'b1};
						end
						state_q <= S_IDLE;
					end
				end
				S_TEMIT: begin
					res_v_q <= 1'b1;
					res_q   <= '{kind: stp_pkg::KIND_EXPIRY, slot_out: 5'(emit_id_q),
						ok: 1'b0, queue_out: 8'(ram_rdata[RW-1:32]),
						payload_out: ram_rdata[31:0], last: !head_exp && !ts_q};
					state_q <= (head_exp || ts_q) ? S_TCHK : S_IDLE;
				end
				S_CALL: begin
					if (call_hit) begin
						status_q[chk_idx_q] <= stp_pkg::ST_FREE;
					end
					if (cnt_q < CW'(NUM_TIMERS)) begin
						chk_v_q   <= 1'b1;
						chk_idx_q <= cnt_q[SW-1:0];
						cnt_q     <= cnt_q + CW'(1);
					end else begin
						chk_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/stp_checker.sv =====
`include "sorted_timeout_timer_pool_defines.svh"

module stp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_valid,
	input stp_pkg::stp_out_t result
);

	// a result only shows while a transaction is in flight
	`STP_ASSERT_NOW(a_res_busy, result_valid, busy, "result outside a transaction")

	// more results follow one that is not last, so the block stays busy
	`STP_ASSERT_NEXT(a_more_busy, result_valid && !result.last, busy, "idle before last result")

	// nothing follows the final result
	`STP_ASSERT_NEXT(a_last_end, result_valid && result.last, !result_valid,
		"result after last")

	// alloc and cancel answer with a single result
	`STP_ASSERT_NOW(a_single, result_valid && (result.kind == stp_pkg::KIND_ALLOC ||
		result.kind == stp_pkg::KIND_CANCEL), result.last, "answer not last")

endmodule

bind sorted_timeout_timer_pool stp_checker u_stp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
